// File: rtl/kgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgd_pkg: shared types and constants of the key gesture debouncer
// Event codes, register indexes, reset values and the structs that travel
// between the configuration bank, the gesture step logic and the output stage.
// ----------------------------------------------------------------------------
package kgd_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MAX_EV   = 3;

    typedef logic [TIME_W-1:0] ms_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_DOWN         = 3'd1,
        EV_UP           = 3'd2,
        EV_CLICK        = 3'd3,
        EV_DOUBLE       = 3'd4,
        EV_HOLD_START   = 3'd5,
        EV_REPEAT       = 3'd6,
        EV_HOLD_RELEASE = 3'd7
    } event_code_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_AFTER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_IV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_IV     = 3'd5;

    // Reset values of the timing registers
    localparam ms_t RST_DEBOUNCE   = 16'd20;
    localparam ms_t RST_DBL_WINDOW = 16'd300;
    localparam ms_t RST_HOLD_START = 16'd500;
    localparam ms_t RST_FAST_AFTER = 16'd2000;
    localparam ms_t RST_REPEAT_IV  = 16'd200;
    localparam ms_t RST_FAST_IV    = 16'd50;

    typedef struct packed {
        ms_t debounce_time;
        ms_t double_click_window;
        ms_t hold_start_time;
        ms_t fast_repeat_after;
        ms_t repeat_interval;
        ms_t fast_repeat_interval;
    } cfg_t;

    // Results of one item: up to three events, index of the last one and
    // the status after the step.
    typedef struct packed {
        event_code_t [MAX_EV-1:0] ev;
        logic [1:0]               last_idx;
        logic                     pressed;
        logic                     held;
    } bundle_t;

endpackage : kgd_pkg
`default_nettype wire

// File: rtl/key_gesture_debouncer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_gesture_debouncer: debounced key with click, double click and hold
// Debounces a raw key level by edge age and classifies gestures (down, up,
// click, double click, hold start, hold repeat, hold release).
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  in        in_valid/in_ready, time_now, raw_pressed  to block
//  out       out_valid/out_ready, event_code,          from block
//            last_of_run, pressed_now, held_now
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  to block
//
//  An input word lands in the input register; the gesture step runs on it
//  once the result register can take its events, and writes up to three
//  events into the result register, which drives out_valid. The output
//  port moves one result word per cycle while out_ready is high, so
//  one-result items flow at one per cycle. The result register frees up
//  in the cycle its last word leaves. Reset clears the key state and
//  loads the default timings; the first item after reset only latches
//  the key level. cfg_ready is always high.
//
module key_gesture_debouncer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [kgd_pkg::TIME_W-1:0]    time_now,
    input  wire logic                          raw_pressed,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         event_code,
    output logic                               last_of_run,
    output logic                               pressed_now,
    output logic                               held_now,
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kgd_pkg::TIME_W-1:0]    cfg_data
);
    import kgd_pkg::*;

    cfg_t    cfg;
    bundle_t bundle;

    // Input register
    logic in_valid_reg;
    ms_t  in_time_reg;
    logic in_raw_reg;

    logic can_load;
    logic step_take;

    // Advance the held word into the gesture step when the result register
    // can take its events.
    assign step_take = in_valid_reg && can_load;
    assign in_ready  = !in_valid_reg || step_take;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Payload holds until the next word is taken
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_time_reg <= time_now;
            in_raw_reg  <= raw_pressed;
        end
    end

    kgd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kgd_gesture u_gesture (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_take (step_take),
        .now       (in_time_reg),
        .raw       (in_raw_reg),
        .cfg       (cfg),
        .bundle    (bundle)
    );

    kgd_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step_take),
        .bundle      (bundle),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code),
        .last_of_run (last_of_run),
        .pressed_now (pressed_now),
        .held_now    (held_now)
    );

endmodule : key_gesture_debouncer
`default_nettype wire

// File: rtl/kgd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgd_cfg_regs: timing register bank
// Six 16-bit timing registers written through an index/data port; writes to
// unknown indexes are dropped.
// ----------------------------------------------------------------------------
module kgd_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [kgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kgd_pkg::TIME_W-1:0]    cfg_data,
    output kgd_pkg::cfg_t                      cfg
);
    import kgd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time        <= RST_DEBOUNCE;
            cfg_reg.double_click_window  <= RST_DBL_WINDOW;
            cfg_reg.hold_start_time      <= RST_HOLD_START;
            cfg_reg.fast_repeat_after    <= RST_FAST_AFTER;
            cfg_reg.repeat_interval      <= RST_REPEAT_IV;
            cfg_reg.fast_repeat_interval <= RST_FAST_IV;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_time        <= cfg_data;
                REG_DBL_WINDOW: cfg_reg.double_click_window  <= cfg_data;
                REG_HOLD_START: cfg_reg.hold_start_time      <= cfg_data;
                REG_FAST_AFTER: cfg_reg.fast_repeat_after    <= cfg_data;
                REG_REPEAT_IV:  cfg_reg.repeat_interval      <= cfg_data;
                REG_FAST_IV:    cfg_reg.fast_repeat_interval <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : kgd_cfg_regs
`default_nettype wire

// File: rtl/kgd_gesture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgd_gesture: debounce and gesture step
// Holds the key state and computes, in one pass, the events of one item and
// the state it leaves behind. State advances only when the step is taken.
// ----------------------------------------------------------------------------
module kgd_gesture (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step_take,
    input  wire logic [kgd_pkg::TIME_W-1:0] now,
    input  wire logic                       raw,
    input  wire kgd_pkg::cfg_t              cfg,
    output kgd_pkg::bundle_t                bundle
);
    import kgd_pkg::*;

    logic started_reg,  started_next;
    logic raw_lvl_reg,  raw_lvl_next;
    logic stable_reg,   stable_next;
    logic hold_reg,     hold_next;
    logic cwait_reg,    cwait_next;
    ms_t  edge_t_reg,   edge_t_next;
    ms_t  rep_t_reg,    rep_t_next;
    ms_t  click_t_reg,  click_t_next;

    ms_t  age_edge;
    ms_t  age_rep;
    ms_t  age_click;
    ms_t  age_rep_svc;
    ms_t  age_click_svc;
    ms_t  age_edge_svc;
    ms_t  interval;
    logic raw_change;
    logic debounced;
    logic press;
    logic release_ev;
    logic ct_fresh;

    event_code_t [MAX_EV-1:0] ev_list;
    logic [1:0]               ev_n;

    // All ages come straight from the registers; where the step has just
    // moved a timestamp to now, the age is zero.
    assign age_edge  = now - edge_t_reg;
    assign age_rep   = now - rep_t_reg;
    assign age_click = now - click_t_reg;

    always_comb
    begin
        started_next = started_reg;
        raw_lvl_next = raw_lvl_reg;
        stable_next  = stable_reg;
        hold_next    = hold_reg;
        cwait_next   = cwait_reg;
        edge_t_next  = edge_t_reg;
        rep_t_next   = rep_t_reg;
        click_t_next = click_t_reg;
        ev_list      = '{default: EV_NONE};
        ev_n         = 2'd0;
        raw_change   = 1'b0;
        debounced    = 1'b0;
        press        = 1'b0;
        release_ev   = 1'b0;
        ct_fresh     = 1'b0;
        age_rep_svc   = age_rep;
        age_click_svc = age_click;
        age_edge_svc  = age_edge;
        interval      = cfg.repeat_interval;

        if (!started_reg)
        begin
            // First item: latch the level only
            started_next = 1'b1;
            raw_lvl_next = raw;
            stable_next  = raw;
            edge_t_next  = now;
            if (raw)
            begin
                rep_t_next = now;
            end
        end
        else
        begin
            raw_change = (raw != raw_lvl_reg);
            if (raw_change)
            begin
                raw_lvl_next = raw;
                edge_t_next  = now;
                age_edge_svc = '0;
            end
            else
            begin
                debounced = (stable_reg != raw_lvl_reg) &&
                            (age_edge >= cfg.debounce_time);
            end
            press      = debounced && raw_lvl_reg;
            release_ev = debounced && !raw_lvl_reg;
            if (debounced)
            begin
                stable_next = raw_lvl_reg;
            end

            if (press)
            begin
                rep_t_next  = now;
                age_rep_svc = '0;
                hold_next   = 1'b0;
                ev_list[ev_n] = EV_DOWN;
                ev_n          = ev_n + 2'd1;
            end

            if (release_ev)
            begin
                ev_list[ev_n] = EV_UP;
                ev_n          = ev_n + 2'd1;
                if (hold_reg)
                begin
                    hold_next     = 1'b0;
                    cwait_next    = 1'b0;
                    ev_list[ev_n] = EV_HOLD_RELEASE;
                    ev_n          = ev_n + 2'd1;
                end
                else if (cwait_reg && (age_click <= cfg.double_click_window))
                begin
                    cwait_next    = 1'b0;
                    ev_list[ev_n] = EV_DOUBLE;
                    ev_n          = ev_n + 2'd1;
                end
                else
                begin
                    if (cwait_reg)
                    begin
                        ev_list[ev_n] = EV_CLICK;
                        ev_n          = ev_n + 2'd1;
                    end
                    cwait_next   = 1'b1;
                    click_t_next = now;
                    ct_fresh     = 1'b1;
                end
            end

            if (ct_fresh)
            begin
                age_click_svc = '0;
            end

            // Service gestures against the time that has passed
            if (stable_next)
            begin
                if (!hold_next && (age_rep_svc >= cfg.hold_start_time))
                begin
                    if (cwait_next)
                    begin
                        cwait_next    = 1'b0;
                        ev_list[ev_n] = EV_CLICK;
                        ev_n          = ev_n + 2'd1;
                    end
                    hold_next     = 1'b1;
                    rep_t_next    = now;
                    ev_list[ev_n] = EV_HOLD_START;
                    ev_n          = ev_n + 2'd1;
                end
                else if (hold_next)
                begin
                    if (age_edge_svc >= cfg.fast_repeat_after)
                    begin
                        interval = cfg.fast_repeat_interval;
                    end
                    if (age_rep_svc >= interval)
                    begin
                        rep_t_next    = now;
                        ev_list[ev_n] = EV_REPEAT;
                        ev_n          = ev_n + 2'd1;
                    end
                end
            end
            else if (cwait_next && (age_click_svc > cfg.double_click_window))
            begin
                cwait_next    = 1'b0;
                ev_list[ev_n] = EV_CLICK;
                ev_n          = ev_n + 2'd1;
            end
        end

        bundle.ev       = ev_list;
        bundle.last_idx = (ev_n == 2'd0) ? 2'd0 : ev_n - 2'd1;
        bundle.pressed  = stable_next;
        bundle.held     = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            raw_lvl_reg <= 1'b0;
            stable_reg  <= 1'b0;
            hold_reg    <= 1'b0;
            cwait_reg   <= 1'b0;
            edge_t_reg  <= '0;
            rep_t_reg   <= '0;
            click_t_reg <= '0;
        end
        else if (step_take)
        begin
            started_reg <= started_next;
            raw_lvl_reg <= raw_lvl_next;
            stable_reg  <= stable_next;
            hold_reg    <= hold_next;
            cwait_reg   <= cwait_next;
            edge_t_reg  <= edge_t_next;
            rep_t_reg   <= rep_t_next;
            click_t_reg <= click_t_next;
        end
    end

endmodule : kgd_gesture
`default_nettype wire

// File: rtl/kgd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgd_out_stage: result register and event serializer
// Holds the events of one item and hands them out one word per handshake.
// Takes the next item's bundle in the cycle its last word leaves.
// ----------------------------------------------------------------------------
module kgd_out_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire kgd_pkg::bundle_t bundle,
    output logic              can_load,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        event_code,
    output logic              last_of_run,
    output logic              pressed_now,
    output logic              held_now
);
    import kgd_pkg::*;

    logic       valid_reg;
    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       is_last;
    logic       take;

    assign is_last  = (idx_reg == bundle_reg.last_idx);
    assign take     = valid_reg && out_ready;
    assign can_load = !valid_reg || (take && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
                idx_reg   <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    event_code = bundle_reg.ev[0];
            2'd1:    event_code = bundle_reg.ev[1];
            default: event_code = bundle_reg.ev[2];
        endcase
    end

    assign out_valid   = valid_reg;
    assign last_of_run = is_last;
    assign pressed_now = bundle_reg.pressed;
    assign held_now    = bundle_reg.held;

endmodule : kgd_out_stage
`default_nettype wire

// File: rtl/kgd_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kgd_port_checker: port-level checks of the key gesture debouncer
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module kgd_port_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] event_code,
    input wire logic       last_of_run,
    input wire logic       pressed_now,
    input wire logic       held_now
);
    import kgd_pkg::*;

    // A stalled result word holds its place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code) &&
        $stable(last_of_run))
        else $error("stalled result word changed or dropped");

    // Words of one run follow each other and share the status
    a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid &&
        pressed_now == $past(pressed_now) && held_now == $past(held_now))
        else $error("run broken or status changed within a run");

    // A hold can only be active on a pressed key
    a_held_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && held_now |-> pressed_now)
        else $error("hold active while key released");

    // Down leaves the key pressed, up leaves it released
    a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_DOWN || event_code == EV_UP) |->
        pressed_now == (event_code == EV_DOWN))
        else $error("edge event disagrees with debounced level");

endmodule : kgd_port_checker

bind key_gesture_debouncer kgd_port_checker u_port_checker (.*);
`default_nettype wire
